// ===== design/oahs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahs_pkg
// Types and codes shared by the open addressing hash set.
// ----------------------------------------------------------------------------
package oahs_pkg;

   // Operation codes.
   localparam logic [2:0] OP_ADD      = 3'd0;
   localparam logic [2:0] OP_CONTAINS = 3'd1;
   localparam logic [2:0] OP_DISCARD  = 3'd2;
   localparam logic [2:0] OP_POP      = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Slot marks.
   localparam logic [1:0] MARK_EMPTY   = 2'd0;
   localparam logic [1:0] MARK_ACTIVE  = 2'd1;
   localparam logic [1:0] MARK_DELETED = 2'd2;

   // Perturbation shift per probe step.
   localparam int unsigned SHIFT_STEP = 5;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] key;
      logic [31:0] hash_value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] popped_key;
      logic [1:0]  status;
      logic [10:0] element_count;
      logic        load_high;
   } rsp_type;

endpackage

// ===== design/oahs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahs_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module oahs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write at the address; the read data is registered and appears in the next cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ===== design/open_addressing_hash_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_set
// Fixed-capacity hash set with perturbed probing and tombstones.
// ----------------------------------------------------------------------------
// Usage: a request word (op, key, hash_value) enters on req_valid/req_ready.
// Each request gives one response word on rsp_valid/rsp_ready with found,
// popped_key, status, element_count and load_high.
// One request is worked on at a time. Slots live in one RAM (mark, hash and
// key side by side) with a registered read, so each probe or scan slot
// takes two steps: the address in S_RD, then the compare in S_CHK or
// S_SCAN. Pop scans slots onward from its finger; a pop on an empty set
// goes straight to its response without reading a slot. Clear sweeps
// every slot. After reset the block clears the slot marks in a pass over
// every slot, during which req_ready stays low.
// The response is held in an output register. While the receiver stalls,
// the block still takes and works one more request, then holds its word
// and keeps req_ready low until the output register is free.
// ----------------------------------------------------------------------------
module open_addressing_hash_set
   import oahs_pkg::*;
#(
   parameter int TABLE_SIZE = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int CW = AW + 1;
   localparam int RW = 66;
   localparam logic [AW-1:0] MASK = AW'(TABLE_SIZE - 1);
   localparam logic [CW+2:0] LOAD_LIMIT = (CW+3)'((TABLE_SIZE - 1) * 3);
   localparam int GW = AW + 2;
   localparam logic [GW-1:0] GUARD = GW'(TABLE_SIZE + 8);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_RD, S_CHK, S_SCAN, S_CLR, S_OUT
   } state_type;

   state_type     state_ff;
   req_type       req_ff;
   logic [AW-1:0] idx_ff, tomb_ff;
   logic [31:0]   perturb_ff;
   logic          has_tomb_ff;
   logic [GW-1:0] steps_ff;
   logic [CW-1:0] active_ff, used_ff;
   logic [AW-1:0] pop_start_ff;
   rsp_type       res_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic          out_load;

   // RAM port.
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [RW-1:0] ram_wdata, ram_rdata;

   oahs_ram #(.WIDTH(RW), .DEPTH(TABLE_SIZE)) u_slots (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   logic [1:0]  rd_mark;
   logic [31:0] rd_hash, rd_key;
   assign rd_mark = ram_rdata[65:64];
   assign rd_hash = ram_rdata[63:32];
   assign rd_key  = ram_rdata[31:0];

   logic [31:0]   perturb_nx;
   logic [AW-1:0] idx_nx;
   logic          hit;
   logic          probe_end;
   assign perturb_nx = perturb_ff >> SHIFT_STEP;
   assign idx_nx = AW'({idx_ff, 2'b00} + {2'b00, idx_ff} + 1 + perturb_nx);
   assign hit = (rd_mark == MARK_ACTIVE) && (rd_hash == req_ff.hash_value)
                && (rd_key == req_ff.key);
   // The probe stops at an empty slot or when the step guard runs out.
   assign probe_end = (rd_mark == MARK_EMPTY) || (steps_ff == GUARD - 1'b1);

   // Load flag from a used count.
   function automatic logic load_of(logic [CW-1:0] u);
      return (CW+3)'({u, 2'b00}) + (CW+3)'(u) >= LOAD_LIMIT;
   endfunction

   // The finished word moves to the output register once it is free.
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // RAM address and write selection.
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = idx_ff;
      ram_wdata = {MARK_EMPTY, 64'd0};
      unique case (state_ff)
         S_INIT, S_CLR: begin
            ram_we = 1'b1;
         end
         S_CHK: begin
            if (req_ff.op == OP_ADD && !hit && probe_end) begin
               if (has_tomb_ff) begin
                  ram_we = 1'b1; ram_addr = tomb_ff;
                  ram_wdata = {MARK_ACTIVE, req_ff.hash_value, req_ff.key};
               end else if (rd_mark == MARK_EMPTY
                            && used_ff + 1'b1 < CW'(TABLE_SIZE)) begin
                  ram_we = 1'b1;
                  ram_wdata = {MARK_ACTIVE, req_ff.hash_value, req_ff.key};
               end
            end else if (req_ff.op == OP_DISCARD && hit) begin
               ram_we = 1'b1;
               ram_wdata = {MARK_DELETED, rd_hash, rd_key};
            end
         end
         S_SCAN: begin
            if (rd_mark == MARK_ACTIVE) begin
               ram_we = 1'b1;
               ram_wdata = {MARK_DELETED, rd_hash, rd_key};
            end
         end
         default: ;
      endcase
   end

   // Control sequencer and registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         active_ff    <= '0;
         used_ff      <= '0;
         pop_start_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Output register: load a finished word, or empty once taken.
         if (out_load) begin
            rsp_ff       <= res_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == MASK) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff <= req_data;
                  res_ff.found         <= 1'b0;
                  res_ff.popped_key    <= '0;
                  res_ff.status        <= ST_OK;
                  res_ff.element_count <= 11'(active_ff);
                  res_ff.load_high     <= load_of(used_ff);
                  has_tomb_ff <= 1'b0;
                  steps_ff    <= '0;
                  perturb_ff  <= req_data.hash_value;
                  unique case (req_data.op)
                     OP_ADD, OP_CONTAINS, OP_DISCARD: begin
                        idx_ff   <= req_data.hash_value[AW-1:0];
                        state_ff <= S_RD;
                     end
                     OP_POP: begin
                        idx_ff <= pop_start_ff;
                        if (active_ff == '0) begin
                           res_ff.status <= ST_EMPTY;
                           state_ff      <= S_OUT;
                        end else begin
                           state_ff <= S_RD;
                        end
                     end
                     OP_CLEAR: begin
                        idx_ff   <= '0;
                        state_ff <= S_CLR;
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_RD: begin
               state_ff <= (req_ff.op == OP_POP) ? S_SCAN : S_CHK;
            end
            S_CHK: begin
               if (hit) begin
                  res_ff.found <= 1'b1;
                  if (req_ff.op == OP_DISCARD) begin
                     active_ff <= active_ff - 1'b1;
                     res_ff.element_count <= 11'(active_ff - 1'b1);
                  end
                  state_ff <= S_OUT;
               end else if (probe_end) begin
                  if (req_ff.op == OP_ADD) begin
                     if (has_tomb_ff) begin
                        active_ff <= active_ff + 1'b1;
                        res_ff.element_count <= 11'(active_ff + 1'b1);
                     end else if (rd_mark == MARK_EMPTY
                                  && used_ff + 1'b1 < CW'(TABLE_SIZE)) begin
                        active_ff <= active_ff + 1'b1;
                        used_ff   <= used_ff + 1'b1;
                        res_ff.element_count <= 11'(active_ff + 1'b1);
                        res_ff.load_high     <= load_of(used_ff + 1'b1);
                     end else begin
                        res_ff.status <= ST_FULL;
                     end
                  end
                  state_ff <= S_OUT;
               end else begin
                  if (rd_mark != MARK_ACTIVE && !has_tomb_ff) begin
                     has_tomb_ff <= 1'b1;
                     tomb_ff     <= idx_ff;
                  end
                  perturb_ff <= perturb_nx;
                  idx_ff     <= idx_nx;
                  steps_ff   <= steps_ff + 1'b1;
                  state_ff   <= S_RD;
               end
            end
            S_SCAN: begin
               // Active count is nonzero, so an active slot is always found.
               if (rd_mark == MARK_ACTIVE) begin
                  res_ff.found         <= 1'b1;
                  res_ff.popped_key    <= rd_key;
                  active_ff            <= active_ff - 1'b1;
                  res_ff.element_count <= 11'(active_ff - 1'b1);
                  pop_start_ff         <= idx_ff + 1'b1;
                  state_ff             <= S_OUT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_CLR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == MASK) begin
                  active_ff    <= '0;
                  used_ff      <= '0;
                  pop_start_ff <= '0;
                  res_ff.element_count <= '0;
                  res_ff.load_high     <= load_of('0);
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      active_ff <= used_ff) else $error("active count exceeds used count");
   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      used_ff < CW'(TABLE_SIZE)) else $error("no empty slot left");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("response dropped while stalled");
   a_one_write_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLR |-> ram_we) else $error("clear sweep skipped a slot");
`endif

endmodule

// ===== sim/open_addressing_hash_set_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_set_test
// Self-checking bench for the open addressing hash set. Request words are
// driven with random gaps, and each one is run through a behavioral copy of
// the table. Every response word is compared field by field against the
// oldest predicted word.
// ----------------------------------------------------------------------------
module open_addressing_hash_set_test;
   import oahs_pkg::*;

   localparam int SLOTS      = 1024;
   localparam int SLOT_MASK  = SLOTS - 1;
   localparam int CYCLE_CAP  = 20000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   open_addressing_hash_set #(.TABLE_SIZE(SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Behavioral copy of the table.
   logic [31:0] shadow_key  [SLOTS];
   logic [31:0] shadow_hash [SLOTS];
   logic [1:0]  shadow_mark [SLOTS];
   int unsigned live_count;
   int unsigned used_slots;
   int unsigned pop_finger;

   rsp_type     pending_rsp [$];
   logic [31:0] live_keys   [$];
   logic [31:0] live_hashes [$];

   int          mismatches;
   int          rsp_seen;
   int unsigned cycle_count;
   bit          quiet_mode;
   int          hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Walks the probe path; returns 1 on a hit, 0 on an empty slot, else -1.
   function automatic int walk_probe(input logic [31:0] k, input logic [31:0] h,
                                     output int slot, output int tomb,
                                     output bit has_tomb);
      int unsigned i;
      logic [31:0] perturb;
      i = h & SLOT_MASK;
      perturb = h;
      has_tomb = 0;
      tomb = 0;
      slot = 0;
      for (int n = 0; n < SLOTS + 8; n++) begin
         if (shadow_mark[i] == MARK_EMPTY) begin
            slot = i;
            return 0;
         end
         if (shadow_mark[i] == MARK_ACTIVE) begin
            if (shadow_hash[i] == h && shadow_key[i] == k) begin
               slot = i;
               return 1;
            end
         end else if (!has_tomb) begin
            has_tomb = 1;
            tomb = i;
         end
         perturb = perturb >> SHIFT_STEP;
         i = (i * 5 + 1 + perturb) & SLOT_MASK;
      end
      return -1;
   endfunction

   // Applies one request to the copy and gives the word it should produce.
   function automatic rsp_type apply_request(input req_type rq);
      rsp_type r;
      int slot, tomb, hit;
      bit has_tomb;
      int unsigned i;
      r = '0;
      case (rq.op)
         OP_ADD: begin
            hit = walk_probe(rq.key, rq.hash_value, slot, tomb, has_tomb);
            if (hit == 1) begin
               r.found = 1'b1;
            end else if (has_tomb) begin
               shadow_mark[tomb] = MARK_ACTIVE;
               shadow_key[tomb] = rq.key;
               shadow_hash[tomb] = rq.hash_value;
               live_count++;
            end else if (hit == 0 && used_slots + 1 < SLOTS) begin
               shadow_mark[slot] = MARK_ACTIVE;
               shadow_key[slot] = rq.key;
               shadow_hash[slot] = rq.hash_value;
               live_count++;
               used_slots++;
            end else begin
               r.status = ST_FULL;
            end
         end
         OP_CONTAINS: begin
            hit = walk_probe(rq.key, rq.hash_value, slot, tomb, has_tomb);
            r.found = (hit == 1);
         end
         OP_DISCARD: begin
            hit = walk_probe(rq.key, rq.hash_value, slot, tomb, has_tomb);
            if (hit == 1) begin
               r.found = 1'b1;
               shadow_mark[slot] = MARK_DELETED;
               live_count--;
            end
         end
         OP_POP: begin
            if (live_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               i = pop_finger & SLOT_MASK;
               for (int n = 0; n < SLOTS; n++) begin
                  if (shadow_mark[i] == MARK_ACTIVE) break;
                  i = (i + 1) & SLOT_MASK;
               end
               r.found = 1'b1;
               r.popped_key = shadow_key[i];
               shadow_mark[i] = MARK_DELETED;
               live_count--;
               pop_finger = (i + 1) & SLOT_MASK;
            end
         end
         OP_CLEAR: begin
            for (int n = 0; n < SLOTS; n++) shadow_mark[n] = MARK_EMPTY;
            live_count = 0;
            used_slots = 0;
            pop_finger = 0;
         end
         default: ;
      endcase
      r.element_count = live_count[10:0];
      r.load_high = (used_slots * 5 >= SLOT_MASK * 3);
      return r;
   endfunction

   // Random gap with a chance of 7 in a hundred, none in quiet mode.
   function automatic bit take_gap();
      return !quiet_mode && ($urandom_range(99) < 7);
   endfunction

   // Sends one request word and records its prediction at acceptance.
   // Valid stays high afterwards until a gap or a drain drops it.
   task automatic send_word(input logic [2:0] op, input logic [31:0] k,
                            input logic [31:0] h);
      req_type rq;
      rq.op = op;
      rq.key = k;
      rq.hash_value = h;
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(apply_request(rq));
      if (op == OP_ADD || op == OP_CLEAR || op == OP_POP || op == OP_DISCARD) begin
         // Keep the list of keys worth revisiting short and roughly current.
         if (op == OP_ADD && live_keys.size() < 200) begin
            live_keys.push_back(k);
            live_hashes.push_back(h);
         end
         if (op == OP_CLEAR) begin
            live_keys.delete();
            live_hashes.delete();
         end
      end
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Response receiver: random stalls plus a long hold on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !take_gap();
      end
   end

   // Response checker.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found || rsp_data.popped_key !== want.popped_key
                || rsp_data.status !== want.status
                || rsp_data.element_count !== want.element_count
                || rsp_data.load_high !== want.load_high) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected f=%b k=%h s=%0d n=%0d l=%b, got f=%b k=%h s=%0d n=%0d l=%b",
                           want.found, want.popped_key, want.status, want.element_count,
                           want.load_high, rsp_data.found, rsp_data.popped_key,
                           rsp_data.status, rsp_data.element_count, rsp_data.load_high);
            end
         end
      end
   end

   // Extremes of the fields, every operation, pop on empty, unused codes.
   task automatic test_directed();
      send_word(OP_POP, 32'h0, 32'h0);
      send_word(OP_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_ADD, 32'h0, 32'h0);
      send_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_ADD, 32'h1234_5678, 32'h0);
      send_word(OP_CONTAINS, 32'h1234_5678, 32'h0);
      send_word(OP_CONTAINS, 32'h1234_5678, 32'h1);
      send_word(OP_DISCARD, 32'h0, 32'h0);
      send_word(OP_DISCARD, 32'h0, 32'h0);
      send_word(OP_ADD, 32'hAAAA_5555, 32'h0);
      send_word(3'd5, 32'h5555_AAAA, 32'hAAAA_5555);
      send_word(3'd6, 32'h0, 32'h0);
      send_word(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_POP, 32'h0, 32'h0);
      send_word(OP_POP, 32'h0, 32'h0);
      send_word(OP_POP, 32'h0, 32'h0);
      send_word(OP_POP, 32'h0, 32'h0);
      send_word(OP_CLEAR, 32'h0, 32'h0);
      send_word(OP_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Overfills the table so that adds report full, then empties it.
   task automatic test_table_full();
      for (int n = 0; n < SLOTS + 4; n++)
         send_word(OP_ADD, $urandom, $urandom_range(SLOTS - 1) | (n < 8 ? 32'h0 : $urandom));
      send_word(OP_CONTAINS, $urandom, $urandom);
      for (int n = 0; n < 6; n++) send_word(OP_POP, 32'h0, 32'h0);
      send_word(OP_ADD, $urandom, $urandom);
      send_word(OP_CLEAR, 32'h0, 32'h0);
   endtask

   // Receiver holds off while the sender keeps offering words.
   task automatic test_back_pressure();
      hold_cycles <= 300;
      for (int n = 0; n < 20; n++) send_word(OP_ADD, $urandom, $urandom);
      drain_all();
   endtask

   // Mostly set traffic on a small key pool so hits and tombstones recur.
   task automatic test_random_ops(input int count, input bit no_gaps);
      logic [2:0]  op;
      logic [31:0] k, h;
      int pick, idx;
      quiet_mode = no_gaps;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40) op = OP_ADD;
         else if (pick < 62) op = OP_CONTAINS;
         else if (pick < 84) op = OP_DISCARD;
         else if (pick < 96) op = OP_POP;
         else if (pick < 98) op = OP_CLEAR;
         else op = 3'($urandom_range(5, 7));
         if (live_keys.size() != 0 && $urandom_range(99) < 55) begin
            idx = $urandom_range(live_keys.size() - 1);
            k = live_keys[idx];
            h = live_hashes[idx];
         end else begin
            k = $urandom;
            h = ($urandom_range(1)) ? $urandom : $urandom_range(63);
         end
         send_word(op, k, h);
      end
      quiet_mode = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      mismatches = 0;
      rsp_seen = 0;
      cycle_count = 0;
      quiet_mode = 0;
      hold_cycles = 0;
      live_count = 0;
      used_slots = 0;
      pop_finger = 0;
      for (int n = 0; n < SLOTS; n++) begin
         shadow_mark[n] = MARK_EMPTY;
         shadow_key[n] = '0;
         shadow_hash[n] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      drain_all();
      test_back_pressure();
      test_random_ops(300, 1'b0);
      test_random_ops(150, 1'b1);
      drain_all();
      test_table_full();
      test_random_ops(100, 1'b0);
      drain_all();
      $display("Covered %0d responses: add, contains, discard, pop and clear,", rsp_seen);
      $display("including a full table, pops on an empty set and unused codes.");
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== open_addressing_hash_set.f =====
design/oahs_pkg.sv
design/oahs_ram.sv
design/open_addressing_hash_set.sv
sim/open_addressing_hash_set_test.sv
